FILE: rtl/fcbp_pkg.sv
// ----------------------------------------------------------------------------
// fcbp_pkg
// Shared types and constants of the file reference to control block parser.
// ----------------------------------------------------------------------------
package fcbp_pkg;

    localparam int NAME_CHARS  = 8;
    localparam int TYPE_CHARS  = 3;
    localparam int STORE_DEPTH = NAME_CHARS + TYPE_CHARS;
    localparam int BLOCK_LEN   = STORE_DEPTH + 1;
    // byte positions travel in the 4-bit byte_index field
    localparam int POS_W       = 4;

    typedef logic [7:0]       t_byte;
    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos LAST_INDEX = t_pos'(BLOCK_LEN - 1);
    localparam t_pos NAME_END   = t_pos'(NAME_CHARS);
    localparam t_pos STORE_END  = t_pos'(STORE_DEPTH);
    localparam t_pos NAME_LAST  = t_pos'(NAME_CHARS - 1);
    localparam t_pos TYPE_LAST  = t_pos'(TYPE_CHARS - 1);

    localparam t_byte CH_NUL   = 8'h00;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_BANG  = 8'h21;
    localparam t_byte CH_STAR  = 8'h2A;
    localparam t_byte CH_COMMA = 8'h2C;
    localparam t_byte CH_DOT   = 8'h2E;
    localparam t_byte CH_COLON = 8'h3A;
    localparam t_byte CH_SEMI  = 8'h3B;
    localparam t_byte CH_LT    = 8'h3C;
    localparam t_byte CH_EQ    = 8'h3D;
    localparam t_byte CH_GT    = 8'h3E;
    localparam t_byte CH_QUEST = 8'h3F;
    localparam t_byte CH_A     = 8'h41;
    localparam t_byte CH_LBR   = 8'h5B;
    localparam t_byte CH_RBR   = 8'h5D;
    localparam t_byte CH_UNDER = 8'h5F;
    localparam t_byte CH_TILDE = 8'h7E;

    typedef enum logic [6:0] {
        PH_DRIVE    = 7'b0000001,
        PH_COLON    = 7'b0000010,
        PH_NAME     = 7'b0000100,
        PH_NAME_END = 7'b0001000,
        PH_TYPE     = 7'b0010000,
        PH_TYPE_END = 7'b0100000,
        PH_SKIP     = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic valid;   // this character decides the outcome
        logic err;     // outcome is an illegal reference
    } t_emit;

endpackage

FILE: rtl/fcbp_core.sv
// ----------------------------------------------------------------------------
// fcbp_core
// Character parser: drive, name and type phases with the 8.3 name store.
// Reports the outcome of the presented character and the finished block.
// ----------------------------------------------------------------------------
module fcbp_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  fcbp_pkg::t_byte                         i_ch,
    input  logic                                    i_accept,
    output fcbp_pkg::t_emit                         o_emit,
    output fcbp_pkg::t_byte [fcbp_pkg::BLOCK_LEN-1:0] o_block
);

    fcbp_pkg::t_phase r_phase, n_phase;
    fcbp_pkg::t_byte  r_drive, n_drive;
    fcbp_pkg::t_pos   r_cpos,  n_cpos;
    fcbp_pkg::t_pos   r_fpos,  n_fpos;
    fcbp_pkg::t_byte  r_store [fcbp_pkg::STORE_DEPTH];
    fcbp_pkg::t_byte  n_store [fcbp_pkg::STORE_DEPTH];

    logic             fill_en;
    fcbp_pkg::t_pos   fill_lo;
    fcbp_pkg::t_pos   fill_hi;
    fcbp_pkg::t_byte  fill_val;
    fcbp_pkg::t_emit  emit;
    fcbp_pkg::t_phase after_phase;

    function automatic logic is_illegal(input fcbp_pkg::t_byte c, input logic in_type);
        logic bad;
        bad = (c == fcbp_pkg::CH_COMMA) || (c == fcbp_pkg::CH_SEMI)
           || (c == fcbp_pkg::CH_COLON) || (c == fcbp_pkg::CH_EQ)
           || (c == fcbp_pkg::CH_LBR)   || (c == fcbp_pkg::CH_RBR)
           || (c == fcbp_pkg::CH_UNDER) || (c == fcbp_pkg::CH_LT)
           || (c == fcbp_pkg::CH_GT)
           || (c < fcbp_pkg::CH_BANG)   || (c > fcbp_pkg::CH_TILDE)
           || (in_type && (c == fcbp_pkg::CH_DOT));
        return bad;
    endfunction

    // after a decision: zero byte restarts, anything else skips to the zero byte
    assign after_phase = (i_ch == fcbp_pkg::CH_NUL) ? fcbp_pkg::PH_DRIVE : fcbp_pkg::PH_SKIP;

    always_comb begin
        n_phase  = r_phase;
        n_drive  = r_drive;
        n_cpos   = r_cpos;
        n_fpos   = r_fpos;
        fill_en  = 1'b0;
        fill_lo  = r_cpos;
        fill_hi  = r_cpos + 4'd1;
        fill_val = i_ch;
        emit     = '0;
        unique case (r_phase)
            fcbp_pkg::PH_DRIVE: begin
                if (i_ch == fcbp_pkg::CH_NUL) begin
                    emit    = '{valid: 1'b1, err: 1'b1};
                    n_phase = after_phase;
                end else begin
                    n_drive = i_ch - fcbp_pkg::CH_A + 8'd1;
                    n_phase = fcbp_pkg::PH_COLON;
                end
            end
            fcbp_pkg::PH_COLON: begin
                if (i_ch != fcbp_pkg::CH_COLON) begin
                    emit    = '{valid: 1'b1, err: 1'b1};
                    n_phase = after_phase;
                end else begin
                    n_cpos  = '0;
                    n_fpos  = '0;
                    n_phase = fcbp_pkg::PH_NAME;
                end
            end
            fcbp_pkg::PH_NAME: begin
                if (i_ch == fcbp_pkg::CH_NUL || i_ch == fcbp_pkg::CH_DOT) begin
                    if (r_fpos == '0) begin
                        emit    = '{valid: 1'b1, err: 1'b1};
                        n_phase = after_phase;
                    end else if (i_ch == fcbp_pkg::CH_DOT) begin
                        fill_en  = 1'b1;
                        fill_hi  = fcbp_pkg::NAME_END;
                        fill_val = fcbp_pkg::CH_SPACE;
                        n_cpos   = fcbp_pkg::NAME_END;
                        n_fpos   = '0;
                        n_phase  = fcbp_pkg::PH_TYPE;
                    end else begin
                        // pad name and type together
                        fill_en  = 1'b1;
                        fill_hi  = fcbp_pkg::STORE_END;
                        fill_val = fcbp_pkg::CH_SPACE;
                        n_cpos   = fcbp_pkg::STORE_END;
                        emit     = '{valid: 1'b1, err: 1'b0};
                        n_phase  = after_phase;
                    end
                end else if (i_ch == fcbp_pkg::CH_STAR) begin
                    fill_en  = 1'b1;
                    fill_hi  = fcbp_pkg::NAME_END;
                    fill_val = fcbp_pkg::CH_QUEST;
                    n_cpos   = fcbp_pkg::NAME_END;
                    n_phase  = fcbp_pkg::PH_NAME_END;
                end else if (is_illegal(i_ch, 1'b0)) begin
                    emit    = '{valid: 1'b1, err: 1'b1};
                    n_phase = after_phase;
                end else begin
                    fill_en = 1'b1;
                    n_cpos  = r_cpos + 4'd1;
                    n_fpos  = r_fpos + 4'd1;
                    if (r_fpos >= fcbp_pkg::NAME_LAST) begin
                        n_phase = fcbp_pkg::PH_NAME_END;
                    end
                end
            end
            fcbp_pkg::PH_NAME_END: begin
                if (i_ch == fcbp_pkg::CH_DOT) begin
                    n_cpos  = fcbp_pkg::NAME_END;
                    n_fpos  = '0;
                    n_phase = fcbp_pkg::PH_TYPE;
                end else if (i_ch != fcbp_pkg::CH_NUL) begin
                    emit    = '{valid: 1'b1, err: 1'b1};
                    n_phase = after_phase;
                end else begin
                    fill_en  = 1'b1;
                    fill_lo  = fcbp_pkg::NAME_END;
                    fill_hi  = fcbp_pkg::STORE_END;
                    fill_val = fcbp_pkg::CH_SPACE;
                    n_cpos   = fcbp_pkg::STORE_END;
                    emit     = '{valid: 1'b1, err: 1'b0};
                    n_phase  = after_phase;
                end
            end
            fcbp_pkg::PH_TYPE: begin
                if (i_ch == fcbp_pkg::CH_STAR || i_ch == fcbp_pkg::CH_NUL) begin
                    fill_en  = 1'b1;
                    fill_hi  = fcbp_pkg::STORE_END;
                    fill_val = (i_ch == fcbp_pkg::CH_STAR) ? fcbp_pkg::CH_QUEST
                                                           : fcbp_pkg::CH_SPACE;
                    n_cpos   = fcbp_pkg::STORE_END;
                    emit     = '{valid: 1'b1, err: 1'b0};
                    n_phase  = after_phase;
                end else if (is_illegal(i_ch, 1'b1)) begin
                    emit    = '{valid: 1'b1, err: 1'b1};
                    n_phase = after_phase;
                end else begin
                    fill_en = 1'b1;
                    n_cpos  = r_cpos + 4'd1;
                    n_fpos  = r_fpos + 4'd1;
                    if (r_fpos >= fcbp_pkg::TYPE_LAST) begin
                        n_phase = fcbp_pkg::PH_TYPE_END;
                    end
                end
            end
            fcbp_pkg::PH_TYPE_END: begin
                emit    = '{valid: 1'b1, err: (i_ch != fcbp_pkg::CH_NUL)};
                n_phase = after_phase;
            end
            fcbp_pkg::PH_SKIP: begin
                if (i_ch == fcbp_pkg::CH_NUL) begin
                    n_phase = fcbp_pkg::PH_DRIVE;
                end
            end
            default: begin
                n_phase = fcbp_pkg::PH_DRIVE;
            end
        endcase
    end

    // fill every store entry inside [fill_lo, fill_hi)
    always_comb begin
        for (int i = 0; i < fcbp_pkg::STORE_DEPTH; i++) begin
            n_store[i] = (fill_en && (fcbp_pkg::t_pos'(i) >= fill_lo)
                          && (fcbp_pkg::t_pos'(i) < fill_hi)) ? fill_val : r_store[i];
        end
    end

    always_comb begin
        o_block[0] = n_drive;
        for (int k = 1; k < fcbp_pkg::BLOCK_LEN; k++) begin
            o_block[k] = n_store[k-1];
        end
    end

    assign o_emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fcbp_pkg::PH_DRIVE;
            r_drive <= '0;
            r_cpos  <= '0;
            r_fpos  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_drive <= n_drive;
            r_cpos  <= n_cpos;
            r_fpos  <= n_fpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_store <= n_store;
        end
    end

endmodule

FILE: rtl/filename_to_fcb_parser.sv
// ----------------------------------------------------------------------------
// filename_to_fcb_parser
// Parses a d:name.typ file reference into an 8.3 file control block.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one character per transaction in tdata; a zero
//   byte ends the reference. One character is accepted every cycle while tready is high.
//   When the outcome is decided, the master channel gives either twelve
//   transactions (drive code, eight name bytes, three type bytes, byte_index
//   0..11, tlast on the last) or one error transaction (tuser high, tdata
//   zero, tlast high). After a decision on a nonzero character the rest of
//   the reference up to the zero byte is dropped without result.
//   The first result byte is valid in the cycle after the deciding
//   character is accepted; the run then drains at one byte per cycle while
//   the receiver is ready, from a 12-byte output buffer.
//   Characters that decide no outcome are taken while the buffer drains; a
//   deciding character waits while the previous run is still in the buffer.
//   When the receiver stalls, the current byte holds on the master port.
//   Reset returns the parser to the drive letter and empties the buffer.
// ----------------------------------------------------------------------------
module filename_to_fcb_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] fcb_byte, [11:8] byte_index, [15:12] zero
    output logic        o_m_tuser,   // [0] status
    output logic        o_m_tlast
);

    fcbp_pkg::t_emit                          emit;
    fcbp_pkg::t_byte [fcbp_pkg::BLOCK_LEN-1:0] block;

    logic                                     s_accept;
    logic                                     m_done;
    logic                                     m_last;
    logic                                     r_busy;
    logic                                     r_err;
    fcbp_pkg::t_pos                           r_idx;
    fcbp_pkg::t_byte [fcbp_pkg::BLOCK_LEN-1:0] r_buf;
    fcbp_pkg::t_byte                          out_byte;

    fcbp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ch     (i_s_tdata),
        .i_accept (s_accept),
        .o_emit   (emit),
        .o_block  (block)
    );

    assign m_last     = r_err || (r_idx == fcbp_pkg::LAST_INDEX);
    assign m_done     = r_busy && i_m_tready && m_last;
    // hold a deciding character until the buffer is free
    assign o_s_tready = !(i_s_tvalid && emit.valid && r_busy && !m_done);
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_err  <= 1'b0;
            r_idx  <= '0;
        end else if (s_accept && emit.valid) begin
            r_busy <= 1'b1;
            r_err  <= emit.err;
            r_idx  <= '0;
        end else if (r_busy && i_m_tready) begin
            if (m_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && emit.valid) begin
            r_buf <= block;
        end
    end

    assign out_byte   = r_err ? '0 : r_buf[r_idx];
    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = {4'd0, r_idx, out_byte};
    assign o_m_tuser  = r_err;
    assign o_m_tlast  = m_last;

endmodule

FILE: rtl/fcbp_checker.sv
// ----------------------------------------------------------------------------
// fcbp_checker
// Port-level checks of the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module fcbp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] o_m_tdata,
    input  logic        o_m_tuser,
    input  logic        o_m_tlast
);

    // stalled transaction keeps valid and payload
    a_m_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("master transaction changed while stalled");

    // an error result is a single zero transaction
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && o_m_tdata == 16'd0))
        else $error("error result is not a single zero transaction");

    // a block run ends at the last control block byte
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser && o_m_tlast)
            |-> (o_m_tdata[11:8] == fcbp_pkg::LAST_INDEX))
        else $error("block run ends at the wrong byte");

    // block bytes leave in order without gaps
    a_run_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> (o_m_tvalid && !o_m_tuser
            && o_m_tdata[11:8] == 4'($past(o_m_tdata[11:8]) + 4'd1)))
        else $error("block run skipped or repeated a byte");

endmodule

bind filename_to_fcb_parser fcbp_checker u_fcbp_checker (.*);

FILE: sim/fcb_checker.sv
// ----------------------------------------------------------------------------
// fcb_checker
// Watches both stream channels of the file reference parser, predicts the
// control block bytes or the error result of every reference, and compares
// each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module fcb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [7:0] fcb_byte, [11:8] byte_index, [15:12] zero
    input  logic        i_m_tuser,   // [0] status
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        fcbp_pkg::t_byte fcb;
        fcbp_pkg::t_pos  idx;
        logic            status;
        logic            last;
    } t_fcb_result;

    t_fcb_result fcb_expected[$];

    // parser state
    fcbp_pkg::t_byte  name_buf [fcbp_pkg::STORE_DEPTH];
    fcbp_pkg::t_byte  drive_code;
    int               wr_pos;
    int               field_cnt;
    fcbp_pkg::t_phase phase;

    function automatic bit is_bad_char(fcbp_pkg::t_byte c, bit in_type);
        case (c)
            fcbp_pkg::CH_COMMA, fcbp_pkg::CH_SEMI, fcbp_pkg::CH_COLON,
            fcbp_pkg::CH_EQ, fcbp_pkg::CH_LBR, fcbp_pkg::CH_RBR,
            fcbp_pkg::CH_UNDER, fcbp_pkg::CH_LT, fcbp_pkg::CH_GT: return 1'b1;
            fcbp_pkg::CH_DOT: return in_type;
            default: return (c < fcbp_pkg::CH_BANG) || (c > fcbp_pkg::CH_TILDE);
        endcase
    endfunction

    task automatic fill_upto(int lim, fcbp_pkg::t_byte v);
        while (wr_pos < lim && wr_pos < fcbp_pkg::STORE_DEPTH) begin
            name_buf[wr_pos] = v;
            wr_pos++;
        end
    endtask

    task automatic finish_ref(fcbp_pkg::t_byte ch);
        // a zero byte decides in place; anything else drops the rest
        phase = (ch == fcbp_pkg::CH_NUL) ? fcbp_pkg::PH_DRIVE : fcbp_pkg::PH_SKIP;
    endtask

    task automatic push_error(fcbp_pkg::t_byte ch);
        t_fcb_result r;
        r.fcb    = '0;
        r.idx    = '0;
        r.status = 1'b1;
        r.last   = 1'b1;
        fcb_expected.push_back(r);
        finish_ref(ch);
    endtask

    task automatic push_block(fcbp_pkg::t_byte ch);
        t_fcb_result r;
        for (int k = 0; k < fcbp_pkg::BLOCK_LEN; k++) begin
            r.fcb    = (k == 0) ? drive_code : name_buf[k-1];
            r.idx    = fcbp_pkg::t_pos'(k);
            r.status = 1'b0;
            r.last   = (k == fcbp_pkg::BLOCK_LEN - 1);
            fcb_expected.push_back(r);
        end
        finish_ref(ch);
    endtask

    task automatic start_type();
        wr_pos    = fcbp_pkg::NAME_CHARS;
        field_cnt = 0;
        phase     = fcbp_pkg::PH_TYPE;
    endtask

    task automatic parse_char(fcbp_pkg::t_byte ch);
        case (phase)
            fcbp_pkg::PH_DRIVE: begin
                if (ch == fcbp_pkg::CH_NUL) begin
                    push_error(ch);
                end else begin
                    drive_code = fcbp_pkg::t_byte'(ch - fcbp_pkg::CH_A + 8'd1);
                    phase      = fcbp_pkg::PH_COLON;
                end
            end
            fcbp_pkg::PH_COLON: begin
                if (ch != fcbp_pkg::CH_COLON) begin
                    push_error(ch);
                end else begin
                    wr_pos    = 0;
                    field_cnt = 0;
                    phase     = fcbp_pkg::PH_NAME;
                end
            end
            fcbp_pkg::PH_NAME: begin
                if (ch == fcbp_pkg::CH_NUL || ch == fcbp_pkg::CH_DOT) begin
                    if (field_cnt == 0) begin
                        push_error(ch);
                    end else begin
                        fill_upto(fcbp_pkg::NAME_CHARS, fcbp_pkg::CH_SPACE);
                        if (ch == fcbp_pkg::CH_DOT) begin
                            start_type();
                        end else begin
                            fill_upto(fcbp_pkg::STORE_DEPTH, fcbp_pkg::CH_SPACE);
                            push_block(ch);
                        end
                    end
                end else if (ch == fcbp_pkg::CH_STAR) begin
                    fill_upto(fcbp_pkg::NAME_CHARS, fcbp_pkg::CH_QUEST);
                    phase = fcbp_pkg::PH_NAME_END;
                end else if (is_bad_char(ch, 1'b0)) begin
                    push_error(ch);
                end else begin
                    fill_upto(wr_pos + 1, ch);
                    field_cnt++;
                    if (field_cnt >= fcbp_pkg::NAME_CHARS) phase = fcbp_pkg::PH_NAME_END;
                end
            end
            fcbp_pkg::PH_NAME_END: begin
                if (ch == fcbp_pkg::CH_DOT) begin
                    start_type();
                end else if (ch != fcbp_pkg::CH_NUL) begin
                    push_error(ch);
                end else begin
                    wr_pos = fcbp_pkg::NAME_CHARS;
                    fill_upto(fcbp_pkg::STORE_DEPTH, fcbp_pkg::CH_SPACE);
                    push_block(ch);
                end
            end
            fcbp_pkg::PH_TYPE: begin
                if (ch == fcbp_pkg::CH_STAR) begin
                    fill_upto(fcbp_pkg::STORE_DEPTH, fcbp_pkg::CH_QUEST);
                    push_block(ch);
                end else if (ch == fcbp_pkg::CH_NUL) begin
                    fill_upto(fcbp_pkg::STORE_DEPTH, fcbp_pkg::CH_SPACE);
                    push_block(ch);
                end else if (is_bad_char(ch, 1'b1)) begin
                    push_error(ch);
                end else begin
                    fill_upto(wr_pos + 1, ch);
                    field_cnt++;
                    if (field_cnt >= fcbp_pkg::TYPE_CHARS) phase = fcbp_pkg::PH_TYPE_END;
                end
            end
            fcbp_pkg::PH_TYPE_END: begin
                if (ch != fcbp_pkg::CH_NUL) push_error(ch);
                else push_block(ch);
            end
            default: begin
                if (ch == fcbp_pkg::CH_NUL) phase = fcbp_pkg::PH_DRIVE;
            end
        endcase
    endtask

    task automatic check_result();
        t_fcb_result e;
        if (fcb_expected.size() == 0) begin
            $error("unexpected result: fcb_byte %0h byte_index %0d status %0b last %0b",
                   i_m_tdata[7:0], i_m_tdata[11:8], i_m_tuser, i_m_tlast);
            o_fail_count++;
        end else begin
            e = fcb_expected.pop_front();
            if (i_m_tdata[7:0] !== e.fcb) begin
                $error("fcb_byte: expected %0h, got %0h", e.fcb, i_m_tdata[7:0]);
                o_fail_count++;
            end
            if (i_m_tdata[11:8] !== e.idx) begin
                $error("byte_index: expected %0d, got %0d", e.idx, i_m_tdata[11:8]);
                o_fail_count++;
            end
            if (i_m_tdata[15:12] !== 4'h0) begin
                $error("tdata pad: expected 0, got %0h", i_m_tdata[15:12]);
                o_fail_count++;
            end
            if (i_m_tuser !== e.status) begin
                $error("status: expected %0b, got %0b", e.status, i_m_tuser);
                o_fail_count++;
            end
            if (i_m_tlast !== e.last) begin
                $error("last: expected %0b, got %0b", e.last, i_m_tlast);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (name_buf[i]) name_buf[i] = '0;
            drive_code   = '0;
            wr_pos       = 0;
            field_cnt    = 0;
            phase        = fcbp_pkg::PH_DRIVE;
            o_fail_count = 0;
            fcb_expected.delete();
        end else begin
            // a result never comes out in the cycle its character goes in
            if (i_m_tvalid && i_m_tready) check_result();
            if (i_s_tvalid && i_s_tready) parse_char(i_s_tdata);
        end
        o_pending = fcb_expected.size();
    end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Feeds the file reference parser with directed references and then with
// random well-formed, broken and noise references under several idling
// patterns, including a long receiver hold-off. The checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 150;
    localparam int PHASE_CHARS = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;

    int          s_idle_pct = 26;
    int          m_idle_pct = 26;
    int          stall_req = 0;
    int          stall_seen = 0;
    int          hold_left = 0;
    int          sent_count = 0;
    int          cycle_count = 0;

    fcbp_pkg::t_byte text_q[$];

    filename_to_fcb_parser uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    fcb_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= m_idle_pct);
        end
    end

    // called and left at a falling edge; tvalid stays high for the next call
    task automatic send_char(fcbp_pkg::t_byte ch);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = ch;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_char(fcbp_pkg::t_byte'(s[i]));
    endtask

    function automatic fcbp_pkg::t_byte pick_name_char();
        string           banned = ",;:=[]_<>.*";
        fcbp_pkg::t_byte c;
        bit              hit;
        do begin
            c   = fcbp_pkg::t_byte'($urandom_range(33, 126));
            hit = 1'b0;
            foreach (banned[i]) if (c == fcbp_pkg::t_byte'(banned[i])) hit = 1'b1;
        end while (hit);
        return c;
    endfunction

    task automatic build_good();
        int nlen;
        int tlen;
        text_q.delete();
        if ($urandom_range(9) == 0) begin
            text_q.push_back(fcbp_pkg::t_byte'($urandom_range(1, 255)));
        end else begin
            text_q.push_back(fcbp_pkg::t_byte'(fcbp_pkg::CH_A + $urandom_range(25)));
        end
        text_q.push_back(fcbp_pkg::CH_COLON);
        nlen = $urandom_range(1, fcbp_pkg::NAME_CHARS);
        for (int i = 0; i < nlen; i++) begin
            if ($urandom_range(9) == 0) begin
                text_q.push_back(fcbp_pkg::CH_STAR);
                break;
            end
            text_q.push_back(pick_name_char());
        end
        case ($urandom_range(3))
            0: ;
            1: text_q.push_back(fcbp_pkg::CH_DOT);
            default: begin
                text_q.push_back(fcbp_pkg::CH_DOT);
                tlen = $urandom_range(1, fcbp_pkg::TYPE_CHARS);
                for (int i = 0; i < tlen; i++) begin
                    if ($urandom_range(5) == 0) begin
                        // junk after a star in the type is ignored
                        text_q.push_back(fcbp_pkg::CH_STAR);
                        repeat ($urandom_range(3))
                            text_q.push_back(fcbp_pkg::t_byte'($urandom_range(1, 255)));
                        break;
                    end
                    text_q.push_back(pick_name_char());
                end
            end
        endcase
        text_q.push_back(fcbp_pkg::CH_NUL);
    endtask

    task automatic build_broken();
        string bad_set = ",;:=[]_<>.";
        int    idx;
        build_good();
        idx = $urandom_range(0, text_q.size() - 2);
        case ($urandom_range(3))
            0: text_q[idx] = fcbp_pkg::t_byte'(bad_set[$urandom_range(bad_set.len() - 1)]);
            1: text_q[idx] = fcbp_pkg::t_byte'($urandom_range(255));
            2: text_q.insert(idx, pick_name_char());
            default: repeat ($urandom_range(3, 6)) text_q.insert(idx, pick_name_char());
        endcase
    endtask

    task automatic build_noise();
        text_q.delete();
        repeat ($urandom_range(1, 6)) text_q.push_back(fcbp_pkg::t_byte'($urandom_range(255)));
        text_q.push_back(fcbp_pkg::CH_NUL);
    endtask

    task automatic send_random_ref();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) build_good();
        else if (pick < 90) build_broken();
        else build_noise();
        foreach (text_q[i]) send_char(text_q[i]);
    endtask

    task automatic run_phase(int s_pct, int m_pct);
        int start;
        s_idle_pct = s_pct;
        m_idle_pct = m_pct;
        start = sent_count;
        while (sent_count - start < PHASE_CHARS) send_random_ref();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero byte in place of the drive letter, then of the colon
        send_char(fcbp_pkg::CH_NUL);
        send_text("A");
        send_char(fcbp_pkg::CH_NUL);
        // missing colon, then the rest is dropped
        send_text("Bx:Q");
        send_char(fcbp_pkg::CH_NUL);
        // empty name, by zero byte and by dot
        send_text("C:");
        send_char(fcbp_pkg::CH_NUL);
        send_text("D:.X");
        send_char(fcbp_pkg::CH_NUL);
        // full fields, drive letter byte FF
        send_char(8'hFF);
        send_text(":ABCDEFGH.XYZ");
        send_char(fcbp_pkg::CH_NUL);
        // star in the name, then too long after it
        send_text("E:AB*X");
        send_char(fcbp_pkg::CH_NUL);
        // star in name and type, characters after the type star ignored
        send_text("F:A*.T*,;_");
        send_char(8'h80);
        send_char(fcbp_pkg::CH_NUL);
        // name too long, type too long
        send_text("G:ABCDEFGHI");
        send_char(fcbp_pkg::CH_NUL);
        send_text("H:A.BCDE");
        send_char(fcbp_pkg::CH_NUL);
        // illegal characters: comma, dot in type, delete, space
        send_text("I:A,");
        send_char(fcbp_pkg::CH_NUL);
        send_text("J:A.B.");
        send_char(fcbp_pkg::CH_NUL);
        send_text("K:~");
        send_char(8'h7F);
        send_char(fcbp_pkg::CH_NUL);
        send_text("L:! ");
        send_char(fcbp_pkg::CH_NUL);
        // empty type pads with spaces
        send_text("M:AB.");
        send_char(fcbp_pkg::CH_NUL);

        run_phase(0, 0);

        // fill the block while the receiver holds off
        s_idle_pct = 0;
        m_idle_pct = 0;
        stall_req++;
        repeat (2) begin
            build_good();
            foreach (text_q[i]) send_char(text_q[i]);
        end
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);

        run_phase(79, 0);
        run_phase(0, 79);
        run_phase(26, 26);

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4 * fcbp_pkg::BLOCK_LEN) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

FILE: filename_to_fcb_parser.f
rtl/fcbp_pkg.sv
rtl/fcbp_core.sv
rtl/filename_to_fcb_parser.sv
rtl/fcbp_checker.sv
sim/fcb_checker.sv
sim/tb.sv
